/* rtl/bair_pkg.sv */
package bair_pkg;

    // default store and grid limits
    localparam int MAX_SRC_DIM_DEF = 256;
    localparam int MAX_DST_DIM_DEF = 256;

    // configuration register indexes
    localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DST_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_DST_HEIGHT = 2'd3;

    localparam int CFG_W = 9;

    // request codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* rtl/bair_div.sv */
module bair_div #(
    parameter int W = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [W-1:0]        i_num,
    input  logic [W-1:0]        i_den,
    output logic [W-1:0]        o_quot,
    output bair_pkg::t_div_stat o_stat
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_q;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [W:0]    w_rem_sh;
    logic [W:0]    w_diff;
    logic          w_fit;

    // one quotient bit per cycle, restoring
    assign w_rem_sh = {r_rem, r_q[W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_den};
    assign w_fit    = (w_rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CW'(W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_fit) begin
                    r_rem <= w_diff[W-1:0];
                    r_q   <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh[W-1:0];
                    r_q   <= {r_q[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot      = r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

/* rtl/box_average_image_resampler.sv */
// Channel   Direction  Handshake                   Payload
// in        request    i_in_valid / o_in_ready     i_op, i_src_col, i_src_row, i_pixel_alpha,
//                                                  i_dst_col, i_dst_row
// out       result     o_out_valid / i_out_ready   o_avg_alpha, o_coord_error
// cfg       write      i_cfg_we                    i_cfg_idx, i_cfg_data
//
// A pixel write gives no result. A read outside the grid goes straight to the output
// state. Any other read runs up to four bound divisions and the final mean, which
// share one bit-serial divider of DIV_W bits, and the box walk reads one pixel per cycle
// from the single store read port.
// Reset is synchronous and clears the sequencer and result valid; the source store is not
// cleared and is undefined until written. o_in_ready is high only while the sequencer is
// idle; a finished result waits in the output register, and a read that completes while
// that register is still full holds until it drains.
module box_average_image_resampler #(
    parameter int MAX_SRC_DIM = bair_pkg::MAX_SRC_DIM_DEF,
    parameter int MAX_DST_DIM = bair_pkg::MAX_DST_DIM_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_op,
    input  logic [7:0]               i_src_col,
    input  logic [7:0]               i_src_row,
    input  logic [7:0]               i_pixel_alpha,
    input  logic [7:0]               i_dst_col,
    input  logic [7:0]               i_dst_row,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [7:0]               o_avg_alpha,
    output logic                     o_coord_error,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [bair_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int SDW       = $clog2(MAX_SRC_DIM + 1);
    localparam int DDW       = $clog2(MAX_DST_DIM + 1);
    localparam int MEM_DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int PW        = 9 + SDW;
    localparam int CNT_W     = $clog2(MEM_DEPTH + 1);
    localparam int SUM_W     = $clog2(MEM_DEPTH * 255 + 1);
    localparam int DIV_W     = (PW > SUM_W) ? PW : SUM_W;

    localparam logic [1:0] TERM_X_LO = 2'd0;
    localparam logic [1:0] TERM_X_HI = 2'd1;
    localparam logic [1:0] TERM_Y_LO = 2'd2;
    localparam logic [1:0] TERM_Y_HI = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DIVGO,
        S_DIVWAIT,
        S_BASE,
        S_WALK,
        S_DRAIN,
        S_AVG,
        S_AVGGO,
        S_AVGWAIT,
        S_OUT
    } t_state;

    // configuration
    logic [bair_pkg::CFG_W-1:0] r_src_width;
    logic [bair_pkg::CFG_W-1:0] r_src_height;
    logic [bair_pkg::CFG_W-1:0] r_dst_width;
    logic [bair_pkg::CFG_W-1:0] r_dst_height;

    logic [SDW-1:0] w_sw;
    logic [SDW-1:0] w_sh;
    logic [DDW-1:0] w_dw;
    logic [DDW-1:0] w_dh;

    // sequencer
    t_state         r_state;
    logic [1:0]     r_term;
    logic [7:0]     r_dc;
    logic [7:0]     r_dr;
    logic [SDW-1:0] r_x0;
    logic [SDW-1:0] r_x1;
    logic [SDW-1:0] r_y0;
    logic [SDW-1:0] r_y1;
    logic [SDW-1:0] r_x;
    logic [SDW-1:0] r_y;
    logic [AW-1:0]  r_row_base;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic           r_rd_vld;
    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_den;
    logic [7:0]     r_avg;
    logic           r_err;

    // store
    logic [7:0]     r_mem [MEM_DEPTH];
    logic [7:0]     r_rd_data;

    logic           w_in_xfer;
    logic           w_wr_ok;
    logic [AW-1:0]  w_wr_addr;
    logic [AW-1:0]  w_rd_addr;

    logic           w_axis;
    logic           w_hi;
    logic [7:0]     w_d;
    logic [SDW-1:0] w_s;
    logic [DDW-1:0] w_dd;
    logic           w_down;
    logic [8:0]     w_mul_op;
    logic [PW-1:0]  w_prod;
    logic [PW-1:0]  w_bound_num;
    logic [SDW-1:0] w_q_idx;
    logic           w_out_free;

    logic             w_div_start;
    logic [DIV_W-1:0] w_div_quot;
    bair_pkg::t_div_stat w_div_stat;

    // clamp: zero reads as one, oversize reads as the maximum
    always_comb begin
        w_sw = (r_src_width == '0) ? SDW'(1) :
               (32'(r_src_width) > MAX_SRC_DIM) ? SDW'(MAX_SRC_DIM) : SDW'(r_src_width);
        w_sh = (r_src_height == '0) ? SDW'(1) :
               (32'(r_src_height) > MAX_SRC_DIM) ? SDW'(MAX_SRC_DIM) : SDW'(r_src_height);
        w_dw = (r_dst_width == '0) ? DDW'(1) :
               (32'(r_dst_width) > MAX_DST_DIM) ? DDW'(MAX_DST_DIM) : DDW'(r_dst_width);
        w_dh = (r_dst_height == '0) ? DDW'(1) :
               (32'(r_dst_height) > MAX_DST_DIM) ? DDW'(MAX_DST_DIM) : DDW'(r_dst_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= bair_pkg::CFG_W'(256);
            r_src_height <= bair_pkg::CFG_W'(256);
            r_dst_width  <= bair_pkg::CFG_W'(128);
            r_dst_height <= bair_pkg::CFG_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bair_pkg::CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                bair_pkg::CFG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                bair_pkg::CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data;
                bair_pkg::CFG_DST_HEIGHT: r_dst_height <= i_cfg_data;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_free = !o_out_valid || i_out_ready;

    assign w_wr_ok   = (32'(i_src_col) < MAX_SRC_DIM) && (32'(i_src_row) < MAX_SRC_DIM);
    assign w_wr_addr = AW'(32'(i_src_row) * MAX_SRC_DIM + 32'(i_src_col));
    assign w_rd_addr = r_row_base + AW'(r_x);

    always_ff @(posedge i_clk) begin
        if (w_in_xfer && (i_op == bair_pkg::OP_WRITE) && w_wr_ok) begin
            r_mem[w_wr_addr] <= i_pixel_alpha;
        end
        if (r_state == S_WALK) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // one bound term: d*S (down) or (d+1)*S - 1 (up) for the low end, (d+1)*S for the high end
    assign w_axis   = r_term[1];
    assign w_hi     = r_term[0];
    assign w_d      = w_axis ? r_dr : r_dc;
    assign w_s      = w_axis ? w_sh : w_sw;
    assign w_dd     = w_axis ? w_dh : w_dw;
    assign w_down   = (32'(w_dd) < 32'(w_s));
    assign w_mul_op = (w_down && !w_hi) ? {1'b0, w_d} : ({1'b0, w_d} + 9'd1);
    assign w_prod   = PW'(w_mul_op) * PW'(w_s);
    assign w_bound_num = w_prod - PW'(!w_down);
    assign w_q_idx  = w_div_quot[SDW-1:0];

    assign w_div_start = (r_state == S_DIVGO) || (r_state == S_AVGGO);

    bair_div #(
        .W (DIV_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_quot  (w_div_quot),
        .o_stat  (w_div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_term      <= TERM_X_LO;
            r_rd_vld    <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_WALK);
            if (r_rd_vld) begin
                r_sum <= r_sum + SUM_W'(r_rd_data);
                r_cnt <= r_cnt + 1'b1;
            end
            // a new result loads in S_OUT instead
            if (o_out_valid && i_out_ready && (r_state != S_OUT)) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer && (i_op == bair_pkg::OP_READ)) begin
                        if ((32'(i_dst_col) >= 32'(w_dw)) || (32'(i_dst_row) >= 32'(w_dh))) begin
                            r_avg   <= 8'd0;
                            r_err   <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_dc    <= i_dst_col;
                            r_dr    <= i_dst_row;
                            r_err   <= 1'b0;
                            r_term  <= TERM_X_LO;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_num   <= DIV_W'(w_bound_num);
                    r_den   <= DIV_W'(w_dd);
                    r_state <= S_DIVGO;
                end
                S_DIVGO: begin
                    r_state <= S_DIVWAIT;
                end
                S_DIVWAIT: begin
                    if (w_div_stat.done) begin
                        case (r_term)
                            TERM_X_LO: begin
                                r_x0 <= w_q_idx;
                                if (!w_down) r_x1 <= w_q_idx + 1'b1;
                            end
                            TERM_X_HI: r_x1 <= w_q_idx;
                            TERM_Y_LO: begin
                                r_y0 <= w_q_idx;
                                if (!w_down) r_y1 <= w_q_idx + 1'b1;
                            end
                            default:   r_y1 <= w_q_idx;
                        endcase
                        // an upscaled axis needs only its low term
                        if ((r_term == TERM_Y_HI) || (!w_down && w_axis)) begin
                            r_state <= S_BASE;
                        end else begin
                            r_term  <= w_down ? (r_term + 1'b1) : TERM_Y_LO;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_BASE: begin
                    r_row_base <= AW'(32'(r_y0) * MAX_SRC_DIM);
                    r_x        <= r_x0;
                    r_y        <= r_y0;
                    r_sum      <= '0;
                    r_cnt      <= '0;
                    r_state    <= S_WALK;
                end
                S_WALK: begin
                    if (SDW'(r_x + 1'b1) == r_x1) begin
                        r_x        <= r_x0;
                        r_y        <= r_y + 1'b1;
                        r_row_base <= r_row_base + AW'(MAX_SRC_DIM);
                        if (SDW'(r_y + 1'b1) == r_y1) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end
                S_DRAIN: begin
                    // last pixel lands in the sum at this edge
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    r_num   <= DIV_W'(r_sum);
                    r_den   <= DIV_W'(r_cnt);
                    r_state <= S_AVGGO;
                end
                S_AVGGO: begin
                    r_state <= S_AVGWAIT;
                end
                S_AVGWAIT: begin
                    if (w_div_stat.done) begin
                        r_avg   <= w_div_quot[7:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        o_out_valid   <= 1'b1;
                        o_avg_alpha   <= r_avg;
                        o_coord_error <= r_err;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_rd_follows_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(r_state == S_WALK))
        else $error("store read data without a walk issue");

    a_walk_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_x < r_x1) && (r_y < r_y1)))
        else $error("walk index left the box");

    a_avg_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AVG) |-> (r_cnt != '0))
        else $error("mean over an empty box");

    a_read_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (i_op == bair_pkg::OP_READ)) |=> (r_state != S_IDLE))
        else $error("read transfer did not start the sequencer");
`endif

endmodule

/* dv/tb_top.sv */
module tb_top;

    localparam int STORE_DIM     = bair_pkg::MAX_SRC_DIM_DEF;
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 30;

    typedef struct {
        logic       op;
        logic [7:0] src_col;
        logic [7:0] src_row;
        logic [7:0] alpha;
        logic [7:0] dst_col;
        logic [7:0] dst_row;
    } t_pixel_req;

    typedef struct {
        logic [7:0] avg;
        logic       err;
    } t_cell_value;

    class resample_scoreboard;
        logic [bair_pkg::CFG_W-1:0] src_w, src_h, dst_w, dst_h;
        logic [7:0]       store [STORE_DIM*STORE_DIM];
        bit               filled [STORE_DIM*STORE_DIM];
        t_cell_value      expected_cells [$];
        int               errors;

        function new();
            src_w  = 9'd256;
            src_h  = 9'd256;
            dst_w  = 9'd128;
            dst_h  = 9'd64;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [bair_pkg::CFG_W-1:0] val);
            case (idx)
                bair_pkg::CFG_SRC_WIDTH:  src_w = val;
                bair_pkg::CFG_SRC_HEIGHT: src_h = val;
                bair_pkg::CFG_DST_WIDTH:  dst_w = val;
                bair_pkg::CFG_DST_HEIGHT: dst_h = val;
                default: ;
            endcase
        endfunction

        function int unsigned clamp_dim(logic [bair_pkg::CFG_W-1:0] v, int unsigned lim);
            if (v == 0) return 1;
            if (v > lim) return lim;
            return v;
        endfunction

        // source span [lo, hi) of destination index d on one axis
        function void axis_span(int unsigned d, int unsigned s, int unsigned dd,
                                output int unsigned lo, output int unsigned hi);
            if (dd < s) begin
                lo = d * s / dd;
                hi = (d + 1) * s / dd;
            end else begin
                lo = ((d + 1) * s - 1) / dd;
                hi = lo + 1;
            end
        endfunction

        // zero when the cell lies outside the grid
        function bit cell_box(logic [7:0] dc, logic [7:0] dr,
                              output int unsigned x0, output int unsigned x1,
                              output int unsigned y0, output int unsigned y1);
            int unsigned sw, sh, dw, dh;
            sw = clamp_dim(src_w, bair_pkg::MAX_SRC_DIM_DEF);
            sh = clamp_dim(src_h, bair_pkg::MAX_SRC_DIM_DEF);
            dw = clamp_dim(dst_w, bair_pkg::MAX_DST_DIM_DEF);
            dh = clamp_dim(dst_h, bair_pkg::MAX_DST_DIM_DEF);
            x0 = 0;
            x1 = 0;
            y0 = 0;
            y1 = 0;
            if (dc >= dw || dr >= dh) return 0;
            axis_span(dc, sw, dw, x0, x1);
            axis_span(dr, sh, dh, y0, y1);
            return 1;
        endfunction

        function bit box_filled(logic [7:0] dc, logic [7:0] dr);
            int unsigned x0, x1, y0, y1, x, y;
            if (!cell_box(dc, dr, x0, x1, y0, y1)) return 1;
            for (y = y0; y < y1; y++)
                for (x = x0; x < x1; x++)
                    if (!filled[y * STORE_DIM + x]) return 0;
            return 1;
        endfunction

        function void note_input(t_pixel_req r);
            int unsigned x0, x1, y0, y1, x, y, sum, cnt;
            t_cell_value v;
            if (r.op == bair_pkg::OP_WRITE) begin
                store[{r.src_row, r.src_col}]  = r.alpha;
                filled[{r.src_row, r.src_col}] = 1'b1;
                return;
            end
            v.avg = 8'd0;
            v.err = 1'b1;
            if (cell_box(r.dst_col, r.dst_row, x0, x1, y0, y1)) begin
                sum = 0;
                cnt = 0;
                for (y = y0; y < y1; y++)
                    for (x = x0; x < x1; x++) begin
                        sum += store[y * STORE_DIM + x];
                        cnt++;
                    end
                v.avg = 8'(sum / cnt);
                v.err = 1'b0;
            end
            expected_cells.push_back(v);
        endfunction

        function void check_result(logic [7:0] avg, logic err);
            t_cell_value e;
            if (expected_cells.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: avg_alpha=%0d coord_error=%0b", avg, err);
                return;
            end
            e = expected_cells.pop_front();
            if (avg !== e.avg || err !== e.err) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: avg_alpha exp %0d got %0d, coord_error exp %0b got %0b",
                             e.avg, avg, e.err, err);
            end
        endfunction
    endclass

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_in_valid    = 1'b0;
    logic             i_op          = bair_pkg::OP_WRITE;
    logic [7:0]       i_src_col     = 8'd0;
    logic [7:0]       i_src_row     = 8'd0;
    logic [7:0]       i_pixel_alpha = 8'd0;
    logic [7:0]       i_dst_col     = 8'd0;
    logic [7:0]       i_dst_row     = 8'd0;
    logic             i_out_ready   = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic [1:0]       i_cfg_idx     = bair_pkg::CFG_SRC_WIDTH;
    logic [bair_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [7:0]       o_avg_alpha;
    logic             o_coord_error;

    resample_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_output    = 1'b0;
    int idle_cycles    = 0;

    always #1 i_clk = ~i_clk;

    box_average_image_resampler i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_src_col     (i_src_col),
        .i_src_row     (i_src_row),
        .i_pixel_alpha (i_pixel_alpha),
        .i_dst_col     (i_dst_col),
        .i_dst_row     (i_dst_row),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_avg_alpha   (o_avg_alpha),
        .o_coord_error (o_coord_error),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // result check and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result(o_avg_alpha, o_coord_error);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int k;
        forever begin
            @(negedge i_clk);
            if (hold_output) begin
                i_out_ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) @(negedge i_clk);
                hold_output = 1'b0;
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(t_pixel_req r);
        int gap;
        gap = 0;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= r.op;
        i_src_col     <= r.src_col;
        i_src_row     <= r.src_row;
        i_pixel_alpha <= r.alpha;
        i_dst_col     <= r.dst_col;
        i_dst_row     <= r.dst_row;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(r);
        @(negedge i_clk);
    endtask

    task automatic write_pixel(logic [7:0] col, logic [7:0] row, logic [7:0] alpha);
        t_pixel_req r;
        r.op      = bair_pkg::OP_WRITE;
        r.src_col = col;
        r.src_row = row;
        r.alpha   = alpha;
        r.dst_col = 8'($urandom_range(255));
        r.dst_row = 8'($urandom_range(255));
        send_item(r);
    endtask

    task automatic read_cell(logic [7:0] col, logic [7:0] row);
        t_pixel_req r;
        r.op      = bair_pkg::OP_READ;
        r.src_col = 8'($urandom_range(255));
        r.src_row = 8'($urandom_range(255));
        r.alpha   = 8'($urandom_range(255));
        r.dst_col = col;
        r.dst_row = row;
        send_item(r);
    endtask

    // drop valid, drain pending results, then let a trailing write finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.expected_cells.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(logic [bair_pkg::CFG_W-1:0] sw, logic [bair_pkg::CFG_W-1:0] sh,
                             logic [bair_pkg::CFG_W-1:0] dw, logic [bair_pkg::CFG_W-1:0] dh);
        logic [1:0]                 idxs [4];
        logic [bair_pkg::CFG_W-1:0] vals [4];
        int k;
        idxs = '{bair_pkg::CFG_SRC_WIDTH, bair_pkg::CFG_SRC_HEIGHT,
                 bair_pkg::CFG_DST_WIDTH, bair_pkg::CFG_DST_HEIGHT};
        vals = '{sw, sh, dw, dh};
        for (k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            sb.set_reg(idxs[k], vals[k]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // write the configured source image, or its top-left corner when it is large
    task automatic fill_source();
        int unsigned w, h, r, c;
        w = sb.clamp_dim(sb.src_w, bair_pkg::MAX_SRC_DIM_DEF);
        h = sb.clamp_dim(sb.src_h, bair_pkg::MAX_SRC_DIM_DEF);
        if (w * h > 256) begin
            if (w > 8) w = 8;
            if (h > 8) h = 8;
        end
        for (r = 0; r < h; r++)
            for (c = 0; c < w; c++)
                write_pixel(8'(c), 8'(r), pick_alpha());
    endtask

    task automatic random_item();
        int unsigned sel, w, h, dw, dh, tries;
        logic [7:0]  dc, dr;
        bit          found;
        sel   = $urandom_range(99);
        w     = sb.clamp_dim(sb.src_w, bair_pkg::MAX_SRC_DIM_DEF);
        h     = sb.clamp_dim(sb.src_h, bair_pkg::MAX_SRC_DIM_DEF);
        dw    = sb.clamp_dim(sb.dst_w, bair_pkg::MAX_DST_DIM_DEF);
        dh    = sb.clamp_dim(sb.dst_h, bair_pkg::MAX_DST_DIM_DEF);
        found = 1'b0;
        dc    = 8'd0;
        dr    = 8'd0;
        if (sel < 65) begin
            // only read cells outside the grid or whose whole box has been written
            for (tries = 0; tries < 16 && !found; tries++) begin
                if ($urandom_range(99) < 20) begin
                    dc = 8'($urandom_range(255));
                    dr = 8'($urandom_range(255));
                end else begin
                    dc = 8'($urandom_range((dw > 24 ? 24 : dw) - 1));
                    dr = 8'($urandom_range((dh > 24 ? 24 : dh) - 1));
                end
                found = sb.box_filled(dc, dr);
            end
            if (found) begin
                read_cell(dc, dr);
                return;
            end
        end
        if (sel < 85)
            write_pixel(8'($urandom_range(w - 1)), 8'($urandom_range(h - 1)), pick_alpha());
        else
            write_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), pick_alpha());
    endtask

    initial begin
        int p, n, r;
        logic [bair_pkg::CFG_W-1:0] cfg [4];
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset sizes: cell (0,0) covers columns 0..1, rows 0..3; mean truncates
        write_pixel(8'd0, 8'd0, 8'd255);
        write_pixel(8'd1, 8'd0, 8'd255);
        write_pixel(8'd0, 8'd1, 8'd255);
        write_pixel(8'd1, 8'd1, 8'd255);
        write_pixel(8'd0, 8'd2, 8'd0);
        write_pixel(8'd1, 8'd2, 8'd0);
        write_pixel(8'd0, 8'd3, 8'd1);
        write_pixel(8'd1, 8'd3, 8'd0);
        read_cell(8'd0, 8'd0);
        read_cell(8'd128, 8'd0);
        read_cell(8'd0, 8'd64);
        read_cell(8'd255, 8'd255);
        write_pixel(8'd255, 8'd255, 8'd0);
        write_pixel(8'd255, 8'd0, 8'd128);
        write_pixel(8'd0, 8'd255, 8'd255);

        // downscale on columns, upscale on rows
        settle();
        configure(9'd3, 9'd2, 9'd2, 9'd5);
        write_pixel(8'd2, 8'd1, 8'd2);
        read_cell(8'd1, 8'd4);
        read_cell(8'd0, 8'd0);
        read_cell(8'd2, 8'd0);
        read_cell(8'd1, 8'd5);

        for (p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: cfg = '{9'd0, 9'd511, 9'd511, 9'd0};
                1: cfg = '{9'd511, 9'd0, 9'd0, 9'd511};
                2: cfg = '{9'd256, 9'd256, 9'd256, 9'd256};
                3: cfg = '{9'd1, 9'd1, 9'd1, 9'd1};
                default: begin
                    for (n = 0; n < 2; n++)
                        cfg[n] = ($urandom_range(9) == 0) ? 9'd0 : 9'($urandom_range(1, 12));
                    for (n = 2; n < 4; n++) begin
                        r = $urandom_range(9);
                        if (r == 0)
                            cfg[n] = 9'd0;
                        else if (r == 1)
                            cfg[n] = 9'($urandom_range(257, 511));
                        else
                            cfg[n] = 9'($urandom_range(1, 16));
                    end
                end
            endcase
            configure(cfg[0], cfg[1], cfg[2], cfg[3]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            fill_source();
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 5 && n == 10) hold_output = 1'b1;
                random_item();
            end
        end

        settle();
        if (sb.errors == 0 && sb.expected_cells.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
